// File: hw/rtl/tcba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcba_pkg
// Shared types and constants for the terminal color blend/amplify unit.
// ----------------------------------------------------------------------------
package tcba_pkg;

    // Fixed-point format of the factor: FRAC_BITS fraction bits, ONE is 1.0.
    localparam int FRAC_BITS = 8;
    localparam int FACTOR_W  = 12;
    localparam int CH_W      = 8;
    localparam int ONE_W     = FRAC_BITS + 1;
    localparam int WGT_W     = (FACTOR_W > ONE_W) ? FACTOR_W : ONE_W;
    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    // Stream widths.
    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 24;

    // Queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic {
        KIND_BLEND   = 1'b0,
        KIND_AMPLIFY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // One classified request: both colors already in RGB, weight prepared.
    typedef struct packed {
        kind_t            kind;
        logic [WGT_W-1:0] weight;
        rgb_t             first;
        rgb_t             second;
    } job_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } q_status_t;

    // Fixed 16-entry palette for the low indices.
    localparam rgb_t PALETTE [16] = '{
        '{8'h45, 8'h47, 8'h5a}, '{8'hf3, 8'h8b, 8'ha8},
        '{8'ha6, 8'he3, 8'ha1}, '{8'hf9, 8'he2, 8'haf},
        '{8'h89, 8'hb4, 8'hfa}, '{8'hf5, 8'hc2, 8'he7},
        '{8'h94, 8'he2, 8'hd5}, '{8'hba, 8'hc2, 8'hde},
        '{8'h58, 8'h5b, 8'h70}, '{8'hf3, 8'h8b, 8'ha8},
        '{8'ha6, 8'he3, 8'ha1}, '{8'hf9, 8'he2, 8'haf},
        '{8'h89, 8'hb4, 8'hfa}, '{8'hf5, 8'hc2, 8'he7},
        '{8'h94, 8'he2, 8'hd5}, '{8'ha6, 8'had, 8'hc8}
    };

    // Channel levels of the 6x6x6 color cube.
    localparam logic [CH_W-1:0] CUBE_LEVEL [6] = '{
        8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255
    };

    localparam logic [7:0] CUBE_BASE = 8'd16;
    localparam logic [7:0] GREY_BASE = 8'd232;

endpackage : tcba_pkg
`default_nettype wire

// File: hw/rtl/terminal_color_blend_amplify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_color_blend_amplify
// Blends two colors or amplifies one; colors may be given as 256-color
// palette indices, which are converted to RGB first.
//
// Channel   Dir  Width  Contents
// s_axis    in   80+3   tdata: first_index, first rgb, second_index,
//                       second rgb, factor; tuser: kind, first/second_indexed
// m_axis    out  24     tdata: out_red, out_green, out_blue
//
// One request per cycle sustained while neither side stalls; no dependence between requests.
// From input accept to output valid a request passes through the front register,
// one queue entry and then the output register.
// Either side may stall; the queue absorbs the difference.
// Reset clears only valid flags, queue pointers and the fill count.
// ----------------------------------------------------------------------------
module terminal_color_blend_amplify (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] first_index, [15:8] first_red, [23:16] first_green,
    // [31:24] first_blue, [39:32] second_index, [47:40] second_red,
    // [55:48] second_green, [63:56] second_blue, [75:64] factor, [79:76] zero
    input  wire logic [tcba_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [0] kind, [1] first_indexed, [2] second_indexed
    input  wire logic [tcba_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    output logic [tcba_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    logic                  push;
    logic                  pop;
    tcba_pkg::job_t        push_job;
    tcba_pkg::job_t        head_job;
    tcba_pkg::q_status_t   q_status;

    // Front: accept and classify.
    tcba_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    // Decoupling queue.
    tcba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back: arithmetic and output register.
    tcba_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // A request pushed into the queue is held there at the next edge.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (q_status.count != '0))
        else $error("queue empty right after a push");

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= tcba_pkg::Q_CNT_W'(tcba_pkg::Q_DEPTH))
        else $error("queue fill count beyond depth");

    // Every pop produces a valid result at the next edge.
    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid)
        else $error("pop without a following output valid");

endmodule : terminal_color_blend_amplify
`default_nettype wire

// File: hw/rtl/tcba_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcba_front
// Accepts requests, turns indexed colors into RGB and prepares the weight,
// then holds the classified request until the queue takes it.
// ----------------------------------------------------------------------------
module tcba_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [tcba_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic [tcba_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input  wire tcba_pkg::q_status_t             q_status,
    output logic                                 push,
    output tcba_pkg::job_t                       push_job
);

    // Normalize a color: direct RGB, palette, cube or grey ramp.
    function automatic tcba_pkg::rgb_t to_rgb(input logic indexed,
                                              input logic [7:0] idx,
                                              input tcba_pkg::rgb_t direct);
        tcba_pkg::rgb_t res;
        logic [7:0] q;
        logic [7:0] rem_r;
        logic [5:0] rem_g;
        logic [2:0] dr;
        logic [2:0] dg;
        logic [2:0] db;
        logic [4:0] gi;
        logic [7:0] grey;
        q     = idx - tcba_pkg::CUBE_BASE;
        dr    = 3'd0;
        dg    = 3'd0;
        for (int k = 1; k < 6; k++)
        begin
            if (q >= 8'(k * 36))
            begin
                dr = 3'(k);
            end
        end
        rem_r = q - ({5'd0, dr} * 8'd36);
        for (int k = 1; k < 6; k++)
        begin
            if (rem_r >= 8'(k * 6))
            begin
                dg = 3'(k);
            end
        end
        rem_g = 6'(rem_r - ({5'd0, dg} * 8'd6));
        db    = rem_g[2:0];
        gi    = 5'(idx - tcba_pkg::GREY_BASE);
        grey  = 8'd8 + ({3'd0, gi} * 8'd10);
        if (!indexed)
        begin
            res = direct;
        end
        else if (idx < tcba_pkg::CUBE_BASE)
        begin
            res = tcba_pkg::PALETTE[idx[3:0]];
        end
        else if (idx < tcba_pkg::GREY_BASE)
        begin
            res.red   = tcba_pkg::CUBE_LEVEL[dr];
            res.green = tcba_pkg::CUBE_LEVEL[dg];
            res.blue  = tcba_pkg::CUBE_LEVEL[db];
        end
        else
        begin
            res = '{grey, grey, grey};
        end
        return res;
    endfunction

    logic                           in_fire;
    logic                           valid_reg;
    logic                           valid_next;
    tcba_pkg::job_t                 job_reg;
    tcba_pkg::job_t                 job_next;
    tcba_pkg::kind_t                in_kind;
    logic [tcba_pkg::WGT_W-1:0]     factor_ext;
    tcba_pkg::rgb_t                 first_direct;
    tcba_pkg::rgb_t                 second_direct;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !valid_reg || !q_status.full;
    assign push          = valid_reg && !q_status.full;
    assign push_job      = job_reg;

    // Unpack the stream fields.
    assign in_kind       = tcba_pkg::kind_t'(s_axis_tuser[0]);
    assign factor_ext    = tcba_pkg::WGT_W'(s_axis_tdata[75:64]);
    assign first_direct  = '{s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]};
    assign second_direct = '{s_axis_tdata[47:40], s_axis_tdata[55:48], s_axis_tdata[63:56]};

    // Classify the request and saturate the opacity for blends.
    always_comb
    begin
        job_next.kind   = in_kind;
        job_next.first  = to_rgb(s_axis_tuser[1], s_axis_tdata[7:0], first_direct);
        job_next.second = to_rgb(s_axis_tuser[2], s_axis_tdata[39:32], second_direct);
        if (in_kind == tcba_pkg::KIND_BLEND && factor_ext > tcba_pkg::ONE)
        begin
            job_next.weight = tcba_pkg::ONE;
        end
        else
        begin
            job_next.weight = factor_ext;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    // Holding register of the front.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_reg <= job_next;
        end
    end

endmodule : tcba_front
`default_nettype wire

// File: hw/rtl/tcba_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcba_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module tcba_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire tcba_pkg::job_t  push_job,
    input  wire logic            pop,
    output tcba_pkg::job_t       head_job,
    output tcba_pkg::q_status_t  status
);

    tcba_pkg::job_t                mem [tcba_pkg::Q_DEPTH];
    logic [tcba_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [tcba_pkg::Q_PTR_W-1:0]  wr_ptr_next;
    logic [tcba_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [tcba_pkg::Q_PTR_W-1:0]  rd_ptr_next;
    logic [tcba_pkg::Q_CNT_W-1:0]  count_reg;
    logic [tcba_pkg::Q_CNT_W-1:0]  count_next;

    assign status.count = count_reg;
    assign status.full  = (count_reg == tcba_pkg::Q_CNT_W'(tcba_pkg::Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_job     = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tcba_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tcba_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + tcba_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tcba_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule : tcba_queue
`default_nettype wire

// File: hw/rtl/tcba_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcba_back
// Carries out the blend or amplify on the request at the queue head and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module tcba_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tcba_pkg::job_t                   head_job,
    input  wire tcba_pkg::q_status_t              q_status,
    output logic                                  pop,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [tcba_pkg::OUT_DATA_W-1:0]       m_axis_tdata
);

    localparam int SUM_W = tcba_pkg::CH_W + tcba_pkg::WGT_W + 1;

    // One channel: weighted mix for a blend, scaled and clamped for amplify.
    function automatic logic [tcba_pkg::CH_W-1:0] chan_calc(
        input tcba_pkg::kind_t                  kind,
        input logic [tcba_pkg::WGT_W-1:0]       weight,
        input logic [tcba_pkg::CH_W-1:0]        f,
        input logic [tcba_pkg::CH_W-1:0]        s);
        logic [SUM_W-1:0]                 pf;
        logic [SUM_W-1:0]                 ps;
        logic [SUM_W-1:0]                 sum;
        logic [SUM_W-1:0]                 scaled;
        logic [tcba_pkg::CH_W-1:0]        res;
        pf     = SUM_W'(f) * SUM_W'(weight);
        ps     = SUM_W'(s) * SUM_W'(tcba_pkg::ONE - weight);
        sum    = pf + ps;
        scaled = pf >> tcba_pkg::FRAC_BITS;
        if (kind == tcba_pkg::KIND_BLEND)
        begin
            res = tcba_pkg::CH_W'(sum >> tcba_pkg::FRAC_BITS);
        end
        else if (scaled > SUM_W'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = scaled[tcba_pkg::CH_W-1:0];
        end
        return res;
    endfunction

    logic                   valid_reg;
    logic                   valid_next;
    tcba_pkg::rgb_t         result_reg;
    tcba_pkg::rgb_t         result_next;

    assign pop           = !q_status.empty && (!valid_reg || m_axis_tready);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {result_reg.blue, result_reg.green, result_reg.red};

    // Per-channel arithmetic.
    always_comb
    begin
        result_next.red   = chan_calc(head_job.kind, head_job.weight,
                                      head_job.first.red, head_job.second.red);
        result_next.green = chan_calc(head_job.kind, head_job.weight,
                                      head_job.first.green, head_job.second.green);
        result_next.blue  = chan_calc(head_job.kind, head_job.weight,
                                      head_job.first.blue, head_job.second.blue);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule : tcba_back
`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the terminal color blend/amplify unit. Directed
// requests hit the factor extremes, opacity saturation, amplify overflow and
// every region of the 256-color palette. Random requests with random gaps
// and output stalls follow. Each result is checked against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 2;
    localparam int RANDOM_COUNT   = 800;
    localparam int CALM_COUNT     = 100;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    localparam tcba_pkg::rgb_t WHITE = '{8'hff, 8'hff, 8'hff};
    localparam tcba_pkg::rgb_t BLACK = '{8'h00, 8'h00, 8'h00};

    // One request as the block sees it, before packing onto the stream.
    typedef struct packed {
        tcba_pkg::kind_t                kind;
        logic                           first_indexed;
        logic [7:0]                     first_index;
        tcba_pkg::rgb_t                 first_rgb;
        logic                           second_indexed;
        logic [7:0]                     second_index;
        tcba_pkg::rgb_t                 second_rgb;
        logic [tcba_pkg::FACTOR_W-1:0]  factor;
    } pixel_req_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // [7:0] first_index, [31:8] first rgb, [39:32] second_index,
    // [63:40] second rgb, [75:64] factor, [79:76] zero
    logic [tcba_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
    // [0] kind, [1] first_indexed, [2] second_indexed
    logic [tcba_pkg::IN_USER_W-1:0]    s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // [7:0] out_red, [15:8] out_green, [23:16] out_blue
    logic [tcba_pkg::OUT_DATA_W-1:0]   m_axis_tdata;

    tcba_pkg::rgb_t expected_pixels[$];
    bit   idle_on = 1'b1;
    int   failures = 0;
    int   blend_count = 0;
    int   amplify_count = 0;
    int   indexed_count = 0;
    int   checked_count = 0;

    terminal_color_blend_amplify DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Turns a color into RGB: direct colors pass, indices go through the
    // palette, the cube or the grey ramp.
    function automatic tcba_pkg::rgb_t resolve_color(logic indexed, logic [7:0] index,
                                                     tcba_pkg::rgb_t direct);
        int             q;
        int             grey;
        tcba_pkg::rgb_t c;
        if (!indexed)
            return direct;
        if (index < tcba_pkg::CUBE_BASE)
        begin
            c = tcba_pkg::PALETTE[index[3:0]];
        end
        else if (index < tcba_pkg::GREY_BASE)
        begin
            q = int'(index) - int'(tcba_pkg::CUBE_BASE);
            c.red   = tcba_pkg::CUBE_LEVEL[q / 36];
            c.green = tcba_pkg::CUBE_LEVEL[(q / 6) % 6];
            c.blue  = tcba_pkg::CUBE_LEVEL[q % 6];
        end
        else
        begin
            grey = 8 + (int'(index) - int'(tcba_pkg::GREY_BASE)) * 10;
            c = '{grey[7:0], grey[7:0], grey[7:0]};
        end
        return c;
    endfunction

    // One channel: blend with opacity clipped at one, or amplify with clipping at 255.
    function automatic logic [7:0] mix_channel(tcba_pkg::kind_t kind, logic [7:0] f,
                                               logic [7:0] s,
                                               logic [tcba_pkg::FACTOR_W-1:0] factor);
        int unsigned unity;
        int unsigned fac;
        int unsigned opacity;
        int unsigned v;
        unity = 32'd1 << tcba_pkg::FRAC_BITS;
        fac   = 32'(factor);
        if (kind == tcba_pkg::KIND_BLEND)
        begin
            opacity = (fac > unity) ? unity : fac;
            v = (32'(f) * opacity + 32'(s) * (unity - opacity)) >> tcba_pkg::FRAC_BITS;
            return v[7:0];
        end
        v = (32'(f) * fac) >> tcba_pkg::FRAC_BITS;
        return (v > 32'd255) ? 8'hff : v[7:0];
    endfunction

    function automatic tcba_pkg::rgb_t predict_pixel(pixel_req_t r);
        tcba_pkg::rgb_t f;
        tcba_pkg::rgb_t s;
        f = resolve_color(r.first_indexed, r.first_index, r.first_rgb);
        s = resolve_color(r.second_indexed, r.second_index, r.second_rgb);
        return '{mix_channel(r.kind, f.red, s.red, r.factor),
                 mix_channel(r.kind, f.green, s.green, r.factor),
                 mix_channel(r.kind, f.blue, s.blue, r.factor)};
    endfunction

    function automatic tcba_pkg::rgb_t random_rgb();
        return tcba_pkg::rgb_t'(24'($urandom));
    endfunction

    // Random request; the factor leans toward the opacity-one boundary.
    function automatic pixel_req_t random_pixel();
        pixel_req_t r;
        r.kind           = tcba_pkg::kind_t'(1'($urandom_range(0, 1)));
        r.first_indexed  = 1'($urandom_range(0, 1));
        r.first_index    = 8'($urandom_range(0, 255));
        r.first_rgb      = random_rgb();
        r.second_indexed = 1'($urandom_range(0, 1));
        r.second_index   = 8'($urandom_range(0, 255));
        r.second_rgb     = random_rgb();
        case ($urandom_range(0, 3))
            0: r.factor = 12'($urandom_range(0, 256));
            1: r.factor = 12'($urandom_range(240, 272));
            2: r.factor = 12'($urandom_range(0, 4095));
            default: r.factor = ($urandom_range(0, 1) != 0) ? 12'hfff : 12'h000;
        endcase
        return r;
    endfunction

    function automatic void note_failure(string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endfunction

    // Sends one request, with an optional gap first, and records its expected result.
    task automatic send_pixel(pixel_req_t r);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, r.factor,
                          r.second_rgb.blue, r.second_rgb.green, r.second_rgb.red,
                          r.second_index,
                          r.first_rgb.blue, r.first_rgb.green, r.first_rgb.red,
                          r.first_index};
        s_axis_tuser  <= {r.second_indexed, r.first_indexed, r.kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_pixels.push_back(predict_pixel(r));
        if (r.kind == tcba_pkg::KIND_BLEND)
            blend_count++;
        else
            amplify_count++;
        indexed_count += int'(r.first_indexed) + int'(r.second_indexed);
    endtask

    task automatic send_colors(tcba_pkg::kind_t kind, logic fi_en, logic [7:0] fi,
                               tcba_pkg::rgb_t f, logic si_en, logic [7:0] si,
                               tcba_pkg::rgb_t s, logic [tcba_pkg::FACTOR_W-1:0] factor);
        pixel_req_t r;
        r = '{kind, fi_en, fi, f, si_en, si, s, factor};
        send_pixel(r);
    endtask

    // Holds the sender off until every outstanding request has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Opacity at zero, one, in between and above one.
    task automatic test_blend_extremes();
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'hff, WHITE, 1'b0, 8'h00, BLACK, 12'd0);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h00, WHITE, 1'b0, 8'hff, BLACK, 12'd256);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h3c, WHITE, 1'b0, 8'hc3, BLACK, 12'hfff);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h00, WHITE, 1'b0, 8'h00, BLACK, 12'd128);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h00, WHITE, 1'b0, 8'h00, BLACK, 12'd1);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h00, BLACK, 1'b0, 8'h00, WHITE, 12'd255);
        send_colors(tcba_pkg::KIND_BLEND, 1'b0, 8'h00, '{8'h12, 8'h34, 8'h56}, 1'b0, 8'h00,
                    '{8'hfe, 8'hdc, 8'hba}, 12'd257);
    endtask

    // Palette, cube corners and grey ramp ends, passed through at unity gain; then two indexed blends.
    task automatic test_palette_lookup();
        logic [7:0] picks [8] = '{8'd0, 8'd7, 8'd8, 8'd15, 8'd16, 8'd231, 8'd232, 8'd255};
        foreach (picks[i])
            send_colors(tcba_pkg::KIND_AMPLIFY, 1'b1, picks[i], random_rgb(), 1'b1,
                        8'($urandom), random_rgb(), 12'd256);
        send_colors(tcba_pkg::KIND_BLEND, 1'b1, 8'd200, random_rgb(), 1'b1, 8'd100,
                    random_rgb(), 12'd0);
        send_colors(tcba_pkg::KIND_BLEND, 1'b1, 8'd3, random_rgb(), 1'b1, 8'd240,
                    random_rgb(), 12'd96);
    endtask

    // Gains of zero, above unity and the largest factor.
    task automatic test_amplify_saturation();
        tcba_pkg::rgb_t mixed = '{8'hff, 8'h80, 8'h01};
        send_colors(tcba_pkg::KIND_AMPLIFY, 1'b0, 8'h00, mixed, 1'b0, 8'h00, WHITE, 12'hfff);
        send_colors(tcba_pkg::KIND_AMPLIFY, 1'b0, 8'h00, mixed, 1'b1, 8'h55, WHITE, 12'd0);
        send_colors(tcba_pkg::KIND_AMPLIFY, 1'b0, 8'h00, mixed, 1'b0, 8'h00, BLACK, 12'd512);
        send_colors(tcba_pkg::KIND_AMPLIFY, 1'b0, 8'h00, mixed, 1'b0, 8'h00, BLACK, 12'd257);
    endtask

    // Random traffic; a pause midway and a last stretch without gaps or stalls.
    task automatic test_random_pixels();
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            if (n == RANDOM_COUNT / 2)
                wait_for_results();
            if (n == RANDOM_COUNT - CALM_COUNT)
                idle_on = 1'b0;
            send_pixel(random_pixel());
        end
    endtask

    // Output side: random stall bursts, and a check of every result taken.
    initial
    begin
        tcba_pkg::rgb_t got;
        tcba_pkg::rgb_t want;
        int             stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]};
                if (expected_pixels.size() == 0)
                begin
                    note_failure($sformatf("unexpected result %02h %02h %02h",
                                           got.red, got.green, got.blue));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                            || got.blue !== want.blue)
                        note_failure($sformatf(
                            "result %0d: expected %02h %02h %02h, got %02h %02h %02h",
                            checked_count, want.red, want.green, want.blue,
                            got.red, got.green, got.blue));
                    checked_count++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = int'($urandom_range(0, 5));
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Ends the run when nothing moves on either side for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_blend_extremes();
        wait_for_results();
        test_palette_lookup();
        test_amplify_saturation();
        test_random_pixels();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_pixels.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_pixels.size()));
        $display("covered %0d blend and %0d amplify requests, %0d indexed colors",
                 blend_count, amplify_count, indexed_count);
        $display("checked %0d results, %0d failures", checked_count, failures);
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
